// File: rtl/core/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the framed case converter
// Register indexes, reset values, the reply descriptor and queue status.
// ----------------------------------------------------------------------------
package fcc_pkg;

  localparam int MAX_PAYLOAD_DEF = 60;
  localparam int LEN_W           = 6;
  localparam int BYTE_W          = 8;
  localparam int CFG_IDX_W       = 2;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h55;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hAA;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd1;

  // one pending reply frame
  typedef struct packed {
    logic             lower;   // 0: upper case, 1: lower case
    logic [LEN_W-1:0] len;
    logic             err;     // sticky error flag as it stood at the closing byte
  } reply_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic wr_slot;   // payload bank the parser fills
    logic rd_slot;   // payload bank the reply engine reads
  } q_status_t;

endpackage

// File: rtl/core/fcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module fcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/fcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_queue: two-entry reply queue
// Slot pointers double as payload bank selects; an entry is retired only
// once the end marker of its reply frame has been loaded for output.
// ----------------------------------------------------------------------------
module fcc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcc_pkg::reply_t     push_entry,
  input  logic                pop,
  output fcc_pkg::reply_t     head,
  output fcc_pkg::q_status_t  status
);
  import fcc_pkg::*;

  reply_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end else begin
        count <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head           = slots[rd_ptr];
  assign status.full    = count[1];
  assign status.empty   = (count == 2'd0);
  assign status.wr_slot = wr_ptr;
  assign status.rd_slot = rd_ptr;

endmodule

// File: rtl/core/fcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_front: frame parser
// Tracks start, operation, length, payload and end of each frame, stores
// the payload in the free bank; queues replies for good op 0 and 1 frames.
// ----------------------------------------------------------------------------
module fcc_front #(
  parameter int MAX_PAYLOAD = fcc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rx_valid,
  output logic                                rx_ready,
  input  logic [fcc_pkg::BYTE_W-1:0]          rx_byte,
  input  logic [fcc_pkg::BYTE_W-1:0]          start_marker,
  input  logic [fcc_pkg::BYTE_W-1:0]          end_marker,
  input  fcc_pkg::q_status_t                  q_stat,
  output logic                                push,
  output fcc_pkg::reply_t                     push_entry,
  output logic                                ram_we,
  output logic [$clog2(2*MAX_PAYLOAD)-1:0]    ram_waddr,
  output logic [fcc_pkg::BYTE_W-1:0]          ram_wdata,
  output logic                                error_latch
);
  import fcc_pkg::*;

  localparam int AW = $clog2(2*MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] OP_LAST = 8'd4;

  typedef enum logic [4:0] {
    P_WAIT = 5'b00001,
    P_OP   = 5'b00010,
    P_LEN  = 5'b00100,
    P_DATA = 5'b01000,
    P_END  = 5'b10000
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [2:0]       op;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_inc;
  logic             take;
  logic             bad;

  assign rx_ready = !q_stat.full;
  assign take     = rx_valid && rx_ready;
  assign cnt_inc  = cnt + LEN_W'(1);

  always_comb begin
    phase_next = phase;
    bad        = 1'b0;
    unique case (phase)
      P_WAIT: phase_next = (rx_byte == start_marker) ? P_OP : P_WAIT;
      P_OP: begin
        if (rx_byte <= OP_LAST) begin
          phase_next = P_LEN;
        end else begin
          phase_next = P_WAIT;
          bad        = 1'b1;
        end
      end
      P_LEN: begin
        if (rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
          phase_next = P_WAIT;
          bad        = 1'b1;
        end else begin
          phase_next = (rx_byte == '0) ? P_END : P_DATA;
        end
      end
      P_DATA: phase_next = (cnt_inc >= len) ? P_END : P_DATA;
      P_END: begin
        phase_next = P_WAIT;
        bad        = (rx_byte != end_marker);
      end
      default: phase_next = P_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= P_WAIT;
      op          <= '0;
      len         <= '0;
      cnt         <= '0;
      error_latch <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      if (bad) begin
        error_latch <= 1'b1;
      end
      if (phase == P_OP) begin
        op <= rx_byte[2:0];
      end
      if (phase == P_LEN) begin
        len <= rx_byte[LEN_W-1:0];
        cnt <= '0;
      end
      if (phase == P_DATA) begin
        cnt <= cnt_inc;
      end
    end
  end

  // payload goes to the bank of the slot about to be filled
  assign ram_we    = take && (phase == P_DATA);
  assign ram_waddr = q_stat.wr_slot ? AW'(MAX_PAYLOAD + int'(cnt)) : AW'(cnt);
  assign ram_wdata = rx_byte;

  // operations 2 to 4 close silently
  assign push = take && (phase == P_END) && !bad && (op[2:1] == 2'b00);
  assign push_entry.lower = op[0];
  assign push_entry.len   = len;
  assign push_entry.err   = error_latch;

endmodule

// File: rtl/core/fcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_back: reply engine
// Sends start marker, operation, length, case-converted payload and end
// marker of the queue head, one byte per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module fcc_back #(
  parameter int MAX_PAYLOAD = fcc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [fcc_pkg::BYTE_W-1:0]          start_marker,
  input  logic [fcc_pkg::BYTE_W-1:0]          end_marker,
  input  fcc_pkg::q_status_t                  q_stat,
  input  fcc_pkg::reply_t                     head,
  output logic                                pop,
  output logic                                ram_re,
  output logic [$clog2(2*MAX_PAYLOAD)-1:0]    ram_raddr,
  input  logic [fcc_pkg::BYTE_W-1:0]          ram_rdata,
  output logic                                busy_data,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fcc_pkg::BYTE_W-1:0]          m_tdata,
  output logic                                m_tlast,
  output logic                                m_tuser
);
  import fcc_pkg::*;

  localparam int AW = $clog2(2*MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] CH_LA   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ   = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_UA   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UZ   = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_SH = 8'h20;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_OPC  = 5'b00010,
    B_LEN  = 5'b00100,
    B_DATA = 5'b01000,
    B_TAIL = 5'b10000
  } bstate_t;

  bstate_t          state;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_inc;
  logic [LEN_W-1:0] rd_idx;
  logic             adv;
  logic             load;
  logic [BYTE_W-1:0] conv;
  logic [BYTE_W-1:0] out_byte;

  assign adv     = !m_tvalid || m_tready;
  assign cnt_inc = cnt + LEN_W'(1);

  always_comb begin
    conv = ram_rdata;
    if (head.lower) begin
      if (ram_rdata >= CH_UA && ram_rdata <= CH_UZ) begin
        conv = ram_rdata + CASE_SH;
      end
    end else begin
      if (ram_rdata >= CH_LA && ram_rdata <= CH_LZ) begin
        conv = ram_rdata - CASE_SH;
      end
    end
  end

  always_comb begin
    load     = adv;
    out_byte = end_marker;
    ram_re   = 1'b0;
    rd_idx   = '0;
    unique case (state)
      B_IDLE: begin
        load     = adv && !q_stat.empty;
        out_byte = start_marker;
      end
      B_OPC: out_byte = {{(BYTE_W-1){1'b0}}, head.lower};
      B_LEN: begin
        out_byte = BYTE_W'(head.len);
        ram_re   = adv && (head.len != '0);
      end
      B_DATA: begin
        out_byte = conv;
        rd_idx   = cnt_inc;
        ram_re   = adv && (cnt_inc < head.len);
      end
      B_TAIL: out_byte = end_marker;
      default: load = 1'b0;
    endcase
  end

  assign ram_raddr = q_stat.rd_slot ? AW'(MAX_PAYLOAD + int'(rd_idx)) : AW'(rd_idx);
  assign pop       = load && (state == B_TAIL);
  assign busy_data = (state == B_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        unique case (state)
          B_IDLE: state <= B_OPC;
          B_OPC:  state <= B_LEN;
          B_LEN: begin
            cnt   <= '0;
            state <= (head.len == '0) ? B_TAIL : B_DATA;
          end
          B_DATA: begin
            cnt <= cnt_inc;
            if (cnt_inc >= head.len) begin
              state <= B_TAIL;
            end
          end
          B_TAIL: state <= B_IDLE;
          default: state <= B_IDLE;
        endcase
      end
    end
  end

  // hold the payload of the output register while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= out_byte;
      m_tlast <= (state == B_TAIL);
      m_tuser <= head.err;
    end
  end

endmodule

// File: rtl/core/framed_case_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_case_converter_unit: framed byte parser with case-converted replies
// Parses start / operation / length / payload / end frames and answers
// operations 0 and 1 with an upper- or lower-cased copy of the frame.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_ stream at one byte per cycle. Good frames
// with operation 0 or 1 queue a reply of length + 4 bytes, which leaves on
// the m_ stream at one byte per cycle while m_tready is high, read back
// from a two-bank payload RAM. Up to two replies may be pending, one per
// bank; while both are pending s_tready stays low until the end marker of
// the older reply has moved into the output register. The payload RAM
// needs no clearing pass after reset. Marker registers are written through
// the cfg_ port (index 0: start marker, index 1: end marker); the user
// must write them only while no frame is in flight, which the block does
// not enforce. cfg_ready is always high and other indexes are ignored.
module framed_case_converter_unit #(
  parameter int MAX_PAYLOAD = fcc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fcc_pkg::BYTE_W-1:0]       s_tdata,    // [7:0] rx_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fcc_pkg::BYTE_W-1:0]       m_tdata,    // [7:0] tx_byte
  output logic                             m_tlast,    // last_byte
  output logic                             m_tuser,    // [0] error_seen
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcc_pkg::BYTE_W-1:0]       cfg_data
);
  import fcc_pkg::*;

  localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
  localparam int AW        = $clog2(RAM_DEPTH);

  logic [BYTE_W-1:0] start_marker;
  logic [BYTE_W-1:0] end_marker;
  q_status_t         q_stat;
  reply_t            push_entry;
  reply_t            head;
  logic              push;
  logic              pop;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              error_latch;
  logic              busy_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_START_MARKER) begin
        start_marker <= cfg_data;
      end
      if (cfg_index == CFG_END_MARKER) begin
        end_marker <= cfg_data;
      end
    end
  end

  fcc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (s_tvalid),
    .rx_ready     (s_tready),
    .rx_byte      (s_tdata),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .error_latch  (error_latch)
  );

  fcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_stat)
  );

  fcc_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcc_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk          (clk),
    .rst          (rst),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .q_stat       (q_stat),
    .head         (head),
    .pop          (pop),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .busy_data    (busy_data),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("reply queued while queue full");

  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("parser and reply engine touch the same payload entry");

  a_data_has_reply: assert property (@(posedge clk) disable iff (rst)
    busy_data |-> !q_stat.empty)
    else $error("payload sent with no pending reply");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(error_latch) && !$past(rst) |-> error_latch)
    else $error("error flag cleared without reset");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the framed case converter
// Feeds the byte stream with directed and random frames, some good and some
// broken, under several marker settings. Random gaps and stalls fall on both
// streams. A local parser model predicts every reply byte, and each byte
// that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import fcc_pkg::*;

  localparam logic [7:0] OP_TO_UPPER    = 8'd0;
  localparam logic [7:0] OP_TO_LOWER    = 8'd1;
  localparam logic [7:0] OP_NO_REPLY_LO = 8'd2;
  localparam logic [7:0] OP_NO_REPLY_HI = 8'd4;
  localparam int CHUNK_BYTES  = 20;
  localparam int IDLE_SETTLE  = 20;
  localparam int NUM_SETTINGS = 5;

  typedef enum logic [2:0] {
    WAIT_START, GET_OP, GET_LEN, GET_DATA, GET_END
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       err;
  } reply_beat_t;

  class case_reply_model;
    reply_beat_t  reply_bytes_due[$];
    logic [7:0]   start_mark;
    logic [7:0]   end_mark;
    parse_phase_t phase;
    logic [7:0]   op;
    logic [5:0]   len;
    logic [5:0]   got;
    logic [7:0]   payload[MAX_PAYLOAD_DEF];
    logic         err_latch;
    int           mismatch_cnt;

    function new();
      start_mark   = START_MARKER_RST;
      end_mark     = END_MARKER_RST;
      phase        = WAIT_START;
      op           = '0;
      len          = '0;
      got          = '0;
      err_latch    = 1'b0;
      mismatch_cnt = 0;
    endfunction

    function void set_marker(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_START_MARKER) begin
        start_mark = value;
      end else if (idx == CFG_END_MARKER) begin
        end_mark = value;
      end
    endfunction

    function logic [7:0] fold_case(logic [7:0] b, logic lower);
      if (!lower && b >= "a" && b <= "z") begin
        return b - 8'd32;
      end
      if (lower && b >= "A" && b <= "Z") begin
        return b + 8'd32;
      end
      return b;
    endfunction

    function void reply_due(logic [7:0] d, logic l);
      reply_beat_t beat;
      beat.data = d;
      beat.last = l;
      beat.err  = err_latch;
      reply_bytes_due.push_back(beat);
    endfunction

    // advance the parser by one received byte
    function void rx_accepted(logic [7:0] c);
      case (phase)
        GET_OP: begin
          if (c <= OP_NO_REPLY_HI) begin
            op    = c;
            phase = GET_LEN;
          end else begin
            err_latch = 1'b1;
            phase     = WAIT_START;
          end
        end
        GET_LEN: begin
          if (c > MAX_PAYLOAD_DEF) begin
            err_latch = 1'b1;
            phase     = WAIT_START;
          end else begin
            len   = c[5:0];
            got   = '0;
            phase = (c == 8'd0) ? GET_END : GET_DATA;
          end
        end
        GET_DATA: begin
          payload[got] = c;
          got = got + 6'd1;
          if (got >= len) begin
            phase = GET_END;
          end
        end
        GET_END: begin
          phase = WAIT_START;
          if (c != end_mark) begin
            err_latch = 1'b1;
          end else if (op == OP_TO_UPPER || op == OP_TO_LOWER) begin
            reply_due(start_mark, 1'b0);
            reply_due(op, 1'b0);
            reply_due({2'b00, len}, 1'b0);
            for (int i = 0; i < len; i++) begin
              reply_due(fold_case(payload[i], op == OP_TO_LOWER), 1'b0);
            end
            reply_due(end_mark, 1'b1);
          end
        end
        default: begin
          phase = (c == start_mark) ? GET_OP : WAIT_START;
        end
      endcase
    endfunction

    function void tx_check(logic [7:0] d, logic l, logic e);
      reply_beat_t want;
      if (reply_bytes_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("ERROR: unexpected reply byte data=%h last=%b err=%b", d, l, e);
        end
        return;
      end
      want = reply_bytes_due.pop_front();
      if (want.data !== d || want.last !== l || want.err !== e) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("ERROR: reply byte exp data=%h last=%b err=%b got data=%h last=%b err=%b",
                   want.data, want.last, want.err, d, l, e);
        end
      end
    endfunction

    function int pending();
      return reply_bytes_due.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  case_reply_model model = new();
  int bytes_sent;
  int frames_sent;
  bit sender_steady;
  int stall_left;
  int steady_left;
  int rx_roll;

  always #6 clk = ~clk;

  framed_case_converter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] rx_byte
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [7:0] tx_byte
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),    // [0] error_seen
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function int sender_gap();
    if (sender_steady || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pick_gap();
  endfunction

  function logic [7:0] payload_byte();
    if ($urandom_range(0, 99) < 60) begin
      return 8'($urandom_range(8'h40, 8'h7F));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [7:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return OP_TO_UPPER;
    end
    if (r < 70) begin
      return OP_TO_LOWER;
    end
    return 8'($urandom_range(OP_NO_REPLY_LO, OP_NO_REPLY_HI));
  endfunction

  // receiver: random stalls with occasional stall-free stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      stall_left  = 0;
      steady_left = 0;
    end else if (steady_left > 0) begin
      steady_left--;
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 5) begin
        steady_left = $urandom_range(50, 200);
        m_tready <= 1'b1;
      end else if (rx_roll < 35) begin
        stall_left = pick_gap() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      model.tx_check(m_tdata, m_tlast, m_tuser);
    end
  end

  // keep tvalid high into the next request unless a gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    model.rx_accepted(b);
    bytes_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_replies_done(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model.set_marker(idx, value);
  endtask

  task automatic set_markers(input logic [7:0] sm, input logic [7:0] em);
    write_reg(CFG_START_MARKER, sm);
    write_reg(CFG_END_MARKER, em);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_good_frame(input logic [7:0] op, input int len);
    send_byte(model.start_mark);
    send_byte(op);
    send_byte(8'(len));
    repeat (len) send_byte(payload_byte());
    send_byte(model.end_mark);
  endtask

  task automatic send_random_frame();
    int kind;
    int len;
    logic [7:0] op;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    op   = pick_op();
    len  = $urandom_range(0, 8);
    sender_steady = ($urandom_range(0, 99) < 15);
    if (kind < 75) begin
      send_good_frame(op, len);
    end else if (kind < 83) begin
      send_byte(model.start_mark);
      send_byte(8'($urandom_range(OP_NO_REPLY_HI + 1, 255)));
    end else if (kind < 89) begin
      send_byte(model.start_mark);
      send_byte(op);
      send_byte(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
    end else if (kind < 95) begin
      send_byte(model.start_mark);
      send_byte(op);
      send_byte(8'(len));
      repeat (len) send_byte(payload_byte());
      do b = 8'($urandom_range(0, 255)); while (b == model.end_mark);
      send_byte(b);
    end else begin
      // stray bytes between frames
      repeat ($urandom_range(1, 4)) begin
        do b = 8'($urandom_range(0, 255)); while (b == model.start_mark);
        send_byte(b);
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [7:0] opening[$];
    logic [7:0] mark_start[NUM_SETTINGS];
    logic [7:0] mark_end[NUM_SETTINGS];

    mark_start = '{START_MARKER_RST, 8'h00, 8'hFF, 8'h00, 8'h7E};
    mark_end   = '{END_MARKER_RST, 8'hFF, 8'h00, 8'h00, 8'h7E};
    mark_start[3] = 8'($urandom_range(0, 255));
    mark_end[3]   = 8'($urandom_range(0, 255));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    opening = '{
      8'hFF, 8'h00,
      // letter boundaries: backquote, a, z, open brace
      START_MARKER_RST, OP_TO_UPPER, 8'd4, 8'h60, 8'h61, 8'h7A, 8'h7B, END_MARKER_RST,
      // letter boundaries: at sign, A, Z, open bracket
      START_MARKER_RST, OP_TO_LOWER, 8'd4, 8'h40, 8'h41, 8'h5A, 8'h5B, END_MARKER_RST,
      START_MARKER_RST, OP_TO_UPPER, 8'd0, END_MARKER_RST,
      START_MARKER_RST, OP_NO_REPLY_HI, 8'd0, END_MARKER_RST,
      START_MARKER_RST, OP_NO_REPLY_HI + 8'd1,
      START_MARKER_RST, OP_TO_UPPER, 8'(MAX_PAYLOAD_DEF + 1),
      START_MARKER_RST, OP_TO_LOWER, 8'd0, 8'h00
    };
    foreach (opening[i]) send_byte(opening[i]);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        wait_replies_done(IDLE_SETTLE);
        set_markers(mark_start[ph], mark_end[ph]);
      end
      if (ph == 1) begin
        send_good_frame(OP_TO_UPPER, MAX_PAYLOAD_DEF);
      end else if (ph == 3) begin
        send_good_frame(OP_TO_LOWER, MAX_PAYLOAD_DEF);
      end
      bytes_sent = 0;
      while (bytes_sent < CHUNK_BYTES) begin
        send_random_frame();
        frames_sent++;
        // hold off until the block has answered everything
        if (frames_sent % 6 == 0) begin
          wait_replies_done(0);
        end
      end
    end

    wait_replies_done(50);
    if (model.pending() != 0) begin
      model.mismatch_cnt++;
      $display("ERROR: %0d reply bytes never arrived", model.pending());
    end
    if (model.mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
